// File: rtl/asmd_pkg.sv
`timescale 1ns / 1ps

package asmd_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 48;
    localparam int unsigned STEPS_W    = 24;
    localparam int unsigned ROOT_STEPS = 16;

    localparam logic [1:0] OP_STEP  = 2'd0;
    localparam logic [1:0] OP_WAKE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;
    localparam logic [1:0] SEL_Z = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_THR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_COOL = 3'd5;

    localparam logic [15:0] RST_STEP_THR  = 16'd2458;
    localparam logic [15:0] RST_REL_THR   = 16'd737;
    localparam logic [15:0] RST_DEBOUNCE  = 16'd250;
    localparam logic [15:0] RST_ALPHA     = 16'd3277;
    localparam logic [15:0] RST_WAKE_THR  = 16'd1966;
    localparam logic [15:0] RST_WAKE_COOL = 16'd1500;
    localparam logic [16:0] BASE_ONE_G    = 17'd16384;

    typedef struct packed {
        logic       load;
        logic       sq_en;
        logic [1:0] sq_sel;
        logic       root_init;
        logic       root_step;
        logic       mag_en;
        logic       mul_en;
        logic       commit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_sample;
    } t_dp_stat;

endpackage

// File: rtl/accel_step_and_motion_detector.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                         Payload
// input     in         i_s_axis_tvalid / o_s_axis_tready i_s_axis_tdata, i_s_axis_tuser
// result    out        o_m_axis_tvalid / i_m_axis_tready o_m_axis_tdata
// config    in         i_cfg_we                          i_cfg_idx, i_cfg_wdata
//
// A sample (op 0 or 1) passes from its transfer through dispatch, the shared squaring multiplier,
// root setup, sixteen square-root iterations, then magnitude, filter multiply and commit; no new
// transfer is taken before commit. Other ops go from dispatch straight to commit.
// Reset is synchronous and restores the configuration and filter state.
// A result waits in the output register; the next sample is taken meanwhile and
// holds at commit only while the previous result is still untaken.

module accel_step_and_motion_detector
    import asmd_pkg::*;
#(
    parameter int unsigned STEP_COUNT_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // accel_x, accel_y, accel_z, time_ms
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // op
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // steps, step_event, wake_event, above_flag, magnitude, zero fill
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    asmd_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_stat          (w_stat),
        .o_cmd           (w_cmd)
    );

    asmd_dpath #(
        .STEP_COUNT_BITS (STEP_COUNT_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

// File: rtl/asmd_ctrl.sv
`timescale 1ns / 1ps

module asmd_ctrl
    import asmd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_axis_tvalid,
    output logic     o_s_axis_tready,
    output logic     o_m_axis_tvalid,
    input  logic     i_m_axis_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_SQR   = 3'd2;
    localparam logic [2:0] S_RINIT = 3'd3;
    localparam logic [2:0] S_ROOT  = 3'd4;
    localparam logic [2:0] S_MAG   = 3'd5;
    localparam logic [2:0] S_MUL   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [3:0] r_cnt;
    logic [3:0] n_cnt;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        o_cmd       = '0;
        o_cmd.sq_sel = r_cnt[1:0];
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_cnt = '0;
                if (i_stat.is_sample) begin
                    n_state = S_SQR;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SQR: begin
                o_cmd.sq_en = 1'b1;
                n_cnt       = r_cnt + 4'd1;
                if (r_cnt == 4'd3) begin
                    n_state = S_RINIT;
                end
            end
            S_RINIT: begin
                o_cmd.root_init = 1'b1;
                n_cnt           = '0;
                n_state         = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_cnt           = r_cnt + 4'd1;
                if (r_cnt == 4'(ROOT_STEPS - 1)) begin
                    n_state = S_MAG;
                end
            end
            S_MAG: begin
                o_cmd.mag_en = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_m_axis_tready))
        else $error("result committed over an untaken result");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_out_valid && r_state == S_IDLE))
        else $error("committed result not presented");

endmodule

// File: rtl/asmd_dpath.sv
`timescale 1ns / 1ps

module asmd_dpath
    import asmd_pkg::*;
#(
    parameter int unsigned STEP_COUNT_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic [IN_USER_W-1:0]  i_in_user,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    logic [15:0] r_step_thr;
    logic [15:0] r_rel_thr;
    logic [15:0] r_debounce;
    logic [15:0] r_alpha;
    logic [15:0] r_wake_thr;
    logic [15:0] r_wake_cool;

    logic [1:0]         r_op;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_z;
    logic [31:0]        r_time;

    logic [31:0]        r_prod;
    logic [31:0]        r_sum;
    logic [31:0]        r_rem;
    logic [31:0]        r_res;
    logic [30:0]        r_bit;
    logic [15:0]        r_mag;
    logic signed [17:0] r_dev;
    logic signed [34:0] r_adj;

    logic [16:0]                r_base;
    logic                       r_above;
    logic [31:0]                r_last_step;
    logic [31:0]                r_last_wake;
    logic [STEP_COUNT_BITS-1:0] r_step_total;

    logic [STEPS_W-1:0] r_o_steps;
    logic               r_o_step_ev;
    logic               r_o_wake_ev;
    logic               r_o_above;
    logic [15:0]        r_o_mag;

    logic signed [15:0]         w_axis;
    logic signed [31:0]         w_sq;
    logic [31:0]                w_trial;
    logic                       w_ge;
    logic [15:0]                w_mag_sat;
    logic signed [18:0]         w_base_sum;
    logic                       w_rise;
    logic                       w_fall;
    logic                       w_deb_ok;
    logic [17:0]                w_absdev;
    logic                       w_wake;
    logic                       w_step_ev;
    logic                       w_wake_ev;
    logic [16:0]                n_base;
    logic                       n_above;
    logic [STEP_COUNT_BITS-1:0] n_step_total;
    logic [31:0]                w_total_ext;

    assign o_stat.is_sample = (r_op == OP_STEP) || (r_op == OP_WAKE);

    always_comb begin
        case (i_cmd.sq_sel)
            SEL_X:   w_axis = r_x;
            SEL_Y:   w_axis = r_y;
            default: w_axis = r_z;
        endcase
    end

    assign w_sq      = w_axis * w_axis;
    assign w_trial   = r_res + {1'b0, r_bit};
    assign w_ge      = (r_rem >= w_trial);
    assign w_mag_sat = (r_res > 32'd65535) ? 16'hFFFF : r_res[15:0];

    assign w_base_sum = $signed({2'b00, r_base}) + r_adj[34:16];
    assign w_rise     = !r_above && (r_dev > $signed({2'b00, r_step_thr}));
    assign w_fall     = r_above && (r_dev < $signed({2'b00, r_rel_thr}));
    assign w_deb_ok   = ((r_time - r_last_step) >= {16'd0, r_debounce});
    assign w_absdev   = r_dev[17] ? 18'(-r_dev) : 18'(r_dev);
    assign w_wake     = (w_absdev > {2'b00, r_wake_thr}) &&
                        ((r_time - r_last_wake) >= {16'd0, r_wake_cool});

    always_comb begin
        n_base       = r_base;
        n_above      = r_above;
        n_step_total = r_step_total;
        w_step_ev    = 1'b0;
        w_wake_ev    = 1'b0;
        case (r_op)
            OP_STEP: begin
                n_base = w_base_sum[16:0];
                if (w_rise) begin
                    n_above = 1'b1;
                    if (w_deb_ok) begin
                        w_step_ev    = 1'b1;
                        n_step_total = r_step_total + 1'b1;
                    end
                end else if (w_fall) begin
                    n_above = 1'b0;
                end
            end
            OP_WAKE: begin
                w_wake_ev = w_wake;
            end
            OP_CLEAR: begin
                n_base       = BASE_ONE_G;
                n_above      = 1'b0;
                n_step_total = '0;
            end
            default: begin
                n_base = r_base;
            end
        endcase
    end

    always_comb begin
        w_total_ext                      = '0;
        w_total_ext[STEP_COUNT_BITS-1:0] = n_step_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_thr  <= RST_STEP_THR;
            r_rel_thr   <= RST_REL_THR;
            r_debounce  <= RST_DEBOUNCE;
            r_alpha     <= RST_ALPHA;
            r_wake_thr  <= RST_WAKE_THR;
            r_wake_cool <= RST_WAKE_COOL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEP_THR:  r_step_thr  <= i_cfg_wdata;
                CFG_REL_THR:   r_rel_thr   <= i_cfg_wdata;
                CFG_DEBOUNCE:  r_debounce  <= i_cfg_wdata;
                CFG_ALPHA:     r_alpha     <= i_cfg_wdata;
                CFG_WAKE_THR:  r_wake_thr  <= i_cfg_wdata;
                CFG_WAKE_COOL: r_wake_cool <= i_cfg_wdata;
                default:       r_alpha     <= r_alpha;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= BASE_ONE_G;
            r_above      <= 1'b0;
            r_last_step  <= '0;
            r_last_wake  <= '0;
            r_step_total <= '0;
        end else if (i_cmd.commit) begin
            r_base       <= n_base;
            r_above      <= n_above;
            r_step_total <= n_step_total;
            if (w_step_ev) begin
                r_last_step <= r_time;
            end
            if (w_wake_ev) begin
                r_last_wake <= r_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_in_user;
            r_x    <= i_in_data[15:0];
            r_y    <= i_in_data[31:16];
            r_z    <= i_in_data[47:32];
            r_time <= i_in_data[79:48];
            r_prod <= '0;
            r_sum  <= '0;
            r_mag  <= '0;
        end else if (i_cmd.sq_en) begin
            r_prod <= w_sq;
            r_sum  <= r_sum + r_prod;
        end
        if (i_cmd.root_init) begin
            r_rem <= r_sum;
            r_res <= '0;
            r_bit <= 31'h4000_0000;
        end else if (i_cmd.root_step) begin
            if (w_ge) begin
                r_rem <= r_rem - w_trial;
                r_res <= (r_res >> 1) + {1'b0, r_bit};
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.mag_en) begin
            r_mag <= w_mag_sat;
            r_dev <= $signed({2'b00, w_mag_sat}) - $signed({1'b0, r_base});
        end
        if (i_cmd.mul_en) begin
            r_adj <= $signed({1'b0, r_alpha}) * r_dev;
        end
        if (i_cmd.commit) begin
            r_o_steps   <= w_total_ext[STEPS_W-1:0];
            r_o_step_ev <= w_step_ev;
            r_o_wake_ev <= w_wake_ev;
            r_o_above   <= n_above;
            r_o_mag     <= r_mag;
        end
    end

    assign o_out_data = {5'd0, r_o_mag, r_o_above, r_o_wake_ev, r_o_step_ev, r_o_steps};

    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_base[16])
        else $error("baseline left the 16-bit range");

    a_wake_keeps_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_op == OP_WAKE) |=> $stable(r_base))
        else $error("wake sample moved the baseline");

    a_events_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> !(r_o_step_ev && r_o_wake_ev))
        else $error("step and wake reported by one transfer");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import asmd_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam int unsigned DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [STEPS_W-1:0] steps;
        logic               step_ev;
        logic               wake_ev;
        logic               above;
        logic [15:0]        mag;
    } t_motion_result;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    logic [15:0]        thr_step     = RST_STEP_THR;
    logic [15:0]        thr_release  = RST_REL_THR;
    logic [15:0]        debounce_ms  = RST_DEBOUNCE;
    logic [15:0]        alpha        = RST_ALPHA;
    logic [15:0]        thr_wake     = RST_WAKE_THR;
    logic [15:0]        wake_cool_ms = RST_WAKE_COOL;
    logic [16:0]        baseline     = BASE_ONE_G;
    logic               above        = 1'b0;
    logic [31:0]        last_step_ms = '0;
    logic [31:0]        last_wake_ms = '0;
    logic [STEPS_W-1:0] model_steps  = '0;

    t_motion_result pending_results[$];
    int unsigned    err_count      = 0;
    int unsigned    send_idle_pct  = 0;
    int unsigned    recv_stall_pct = 0;

    accel_step_and_motion_detector #(
        .STEP_COUNT_BITS(STEPS_W)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [15:0] floor_root(logic [31:0] v);
        logic [15:0] root;
        logic [15:0] trial;
        root = '0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (16'd1 << b);
            if (longint'(trial) * longint'(trial) <= longint'(v)) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic t_motion_result predict_motion(logic [1:0] op, logic signed [15:0] ax,
                                                      logic signed [15:0] ay,
                                                      logic signed [15:0] az, logic [31:0] now);
        t_motion_result res;
        longint         sq_sum;
        longint         dev;
        longint         adj;
        logic [15:0]    mag;
        logic [31:0]    elapsed;
        res = '0;
        mag = '0;
        if (op == OP_STEP || op == OP_WAKE) begin
            sq_sum = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
                   + longint'(az) * longint'(az);
            mag = floor_root(sq_sum[31:0]);
        end
        if (op == OP_STEP) begin
            dev = longint'(mag) - longint'(baseline);
            adj = (longint'(alpha) * dev) >>> 16;
            baseline = 17'(longint'(baseline) + adj);
            if (!above && dev > longint'(thr_step)) begin
                above = 1'b1;
                elapsed = now - last_step_ms;
                if (elapsed >= 32'(debounce_ms)) begin
                    last_step_ms = now;
                    model_steps = model_steps + 1'b1;
                    res.step_ev = 1'b1;
                end
            end else if (above && dev < longint'(thr_release)) begin
                above = 1'b0;
            end
        end else if (op == OP_WAKE) begin
            dev = longint'(mag) - longint'(baseline);
            if (dev < 0) begin
                dev = -dev;
            end
            elapsed = now - last_wake_ms;
            if (dev > longint'(thr_wake) && elapsed >= 32'(wake_cool_ms)) begin
                last_wake_ms = now;
                res.wake_ev = 1'b1;
            end
        end else if (op == OP_CLEAR) begin
            model_steps = '0;
            baseline = BASE_ONE_G;
            above = 1'b0;
        end
        res.steps = model_steps;
        res.above = above;
        res.mag = mag;
        return res;
    endfunction

    task automatic check_field(input string what, input int unsigned want, input int unsigned got);
        if (want != got) begin
            err_count++;
            $display("%0t ns: %s expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_motion_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t ns: result transfer with nothing expected, actual %h",
                         $time, o_m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("steps", want.steps, o_m_axis_tdata[23:0]);
                check_field("step_event", want.step_ev, o_m_axis_tdata[24]);
                check_field("wake_event", want.wake_ev, o_m_axis_tdata[25]);
                check_field("above_flag", want.above, o_m_axis_tdata[26]);
                check_field("magnitude", want.mag, o_m_axis_tdata[42:27]);
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic signed [15:0] ax,
                             input logic signed [15:0] ay, input logic signed [15:0] az,
                             input logic [31:0] now);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {now, az, ay, ax};
        i_s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        pending_results.push_back(predict_motion(op, ax, ay, az, now));
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_STEP_THR:  thr_step = val;
            CFG_REL_THR:   thr_release = val;
            CFG_DEBOUNCE:  debounce_ms = val;
            CFG_ALPHA:     alpha = val;
            CFG_WAKE_THR:  thr_wake = val;
            CFG_WAKE_COOL: wake_cool_ms = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [15:0] s, input logic [15:0] r, input logic [15:0] d,
                             input logic [15:0] a, input logic [15:0] w, input logic [15:0] c);
        write_reg(CFG_STEP_THR, s);
        write_reg(CFG_REL_THR, r);
        write_reg(CFG_DEBOUNCE, d);
        write_reg(CFG_ALPHA, a);
        write_reg(CFG_WAKE_THR, w);
        write_reg(CFG_WAKE_COOL, c);
    endtask

    task automatic test_field_extremes();
        send_item(OP_NONE, 16'h7FFF, 16'h8000, 16'h5A5A, 32'hDEAD_BEEF);
        send_item(OP_STEP, 16'sd0, 16'sd0, 16'sd0, 32'd0);
        send_item(OP_STEP, -16'sd32768, -16'sd32768, -16'sd32768, 32'hFFFF_FFFF);
        send_item(OP_STEP, 16'sd32767, 16'sd32767, 16'sd32767, 32'd5);
        send_item(OP_WAKE, -16'sd32768, 16'sd32767, 16'sd0, 32'd1500);
        send_item(OP_WAKE, 16'sd0, 16'sd0, 16'sd0, 32'd1600);
        send_item(OP_CLEAR, 16'sd12345, -16'sd1, 16'sd7, 32'd1700);
        send_item(OP_STEP, 16'sd16384, 16'sd0, 16'sd0, 32'd1800);
        send_item(OP_WAKE, 16'sd0, -16'sd32768, 16'sd0, 32'hFFFF_FFFF);
    endtask

    // With the filter weight at zero the baseline stays at one g, so exact deviations can be set.
    task automatic test_threshold_edges();
        logic [31:0] t0;
        t0 = 32'h8000_0000;
        drain_results();
        write_all(16'd1000, 16'd500, 16'd100, 16'd0, 16'd800, 16'd200);
        send_item(OP_CLEAR, 16'sd0, 16'sd0, 16'sd0, t0);
        send_item(OP_STEP, 16'sd17384, 16'sd0, 16'sd0, t0);
        send_item(OP_STEP, 16'sd17385, 16'sd0, 16'sd0, t0);
        send_item(OP_STEP, 16'sd16884, 16'sd0, 16'sd0, t0 + 10);
        send_item(OP_STEP, 16'sd16883, 16'sd0, 16'sd0, t0 + 20);
        send_item(OP_STEP, 16'sd0, -16'sd17385, 16'sd0, t0 + 99);
        send_item(OP_STEP, 16'sd16000, 16'sd0, 16'sd0, t0 + 99);
        send_item(OP_STEP, 16'sd0, 16'sd0, 16'sd17385, t0 + 100);
        send_item(OP_WAKE, 16'sd17184, 16'sd0, 16'sd0, t0 + 300);
        send_item(OP_WAKE, 16'sd15583, 16'sd0, 16'sd0, t0 + 300);
        send_item(OP_WAKE, 16'sd15583, 16'sd0, 16'sd0, t0 + 499);
        send_item(OP_WAKE, 16'sd15583, 16'sd0, 16'sd0, t0 + 500);
    endtask

    task automatic test_random_gait();
        logic [1:0]         op;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [31:0]        gait_ms;
        int                 mag_target;
        int unsigned        pick;
        logic               peak;
        gait_ms = 32'd1000;
        peak = 1'b0;
        for (int phase = 0; phase < 8; phase++) begin
            drain_results();
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 58;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 58;
                end
                default: begin
                    send_idle_pct = 20;
                    recv_stall_pct = 20;
                end
            endcase
            case (phase)
                0: write_all(RST_STEP_THR, RST_REL_THR, RST_DEBOUNCE, RST_ALPHA, RST_WAKE_THR,
                             RST_WAKE_COOL);
                1: write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                2: begin
                    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                    write_reg(CFG_SPARE_A, 16'($urandom));
                    write_reg(CFG_SPARE_B, 16'($urandom));
                end
                default: write_all(16'($urandom_range(300, 5000)), 16'($urandom_range(0, 2000)),
                                   16'($urandom_range(0, 600)), 16'($urandom),
                                   16'($urandom_range(300, 5000)),
                                   16'($urandom_range(0, 3000)));
            endcase
            for (int i = 0; i < 140; i++) begin
                if (i == 70) begin
                    drain_results();
                end
                pick = $urandom_range(99);
                if (pick < 15) begin
                    op = 2'($urandom_range(3));
                    ax = 16'($urandom);
                    ay = 16'($urandom);
                    az = 16'($urandom);
                    gait_ms = (pick < 5) ? 32'($urandom) : gait_ms + $urandom_range(0, 2000);
                end else begin
                    pick = $urandom_range(99);
                    op = (pick < 72) ? OP_STEP : (pick < 94) ? OP_WAKE :
                         (pick < 98) ? OP_CLEAR : OP_NONE;
                    peak = !peak;
                    mag_target = peak ? 16384 + int'($urandom_range(500, 9000))
                                      : 16384 - int'($urandom_range(0, 3000));
                    if ($urandom_range(1) == 1) begin
                        mag_target = -mag_target;
                    end
                    ax = 16'(int'($urandom_range(0, 400)) - 200);
                    ay = 16'(int'($urandom_range(0, 400)) - 200);
                    az = 16'(int'($urandom_range(0, 400)) - 200);
                    case ($urandom_range(2))
                        0: ax = 16'(mag_target);
                        1: ay = 16'(mag_target);
                        default: az = 16'(mag_target);
                    endcase
                    gait_ms = gait_ms + $urandom_range(5, 420);
                end
                send_item(op, ax, ay, az, gait_ms);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_threshold_edges();
        test_random_gait();
        drain_results();
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: accel_step_and_motion_detector.f
rtl/asmd_pkg.sv
rtl/asmd_ctrl.sv
rtl/asmd_dpath.sv
rtl/accel_step_and_motion_detector.sv
dv/tb_top.sv
